// ===== hw/rtl/fmd_pkg.sv =====
// fmd_pkg: shared types, constants and helpers for the message deframer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package fmd_pkg;

   localparam int LEN_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH      = 4;
   localparam int CFG_BITS         = 16;

   localparam logic [7:0] SOH_BYTE    = 8'h01;
   localparam logic [7:0] CHAR_EIGHT  = 8'h38;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
   localparam logic [7:0] CHAR_F      = 8'h46;
   localparam logic [7:0] CHAR_I      = 8'h49;
   localparam logic [7:0] CHAR_X      = 8'h58;
   localparam logic [2:0] BEGIN_LAST  = 3'd4;
   localparam logic [3:0] TRAILER_LEN = 4'd7;
   localparam logic [15:0] CFG_RESET  = 16'hFFFF;

   typedef enum logic [3:0] {
      PH_HUNT   = 4'b0001,
      PH_HEADER = 4'b0010,
      PH_LENGTH = 4'b0100,
      PH_BODY   = 4'b1000
   } phase_type;

   // one queued word: either a plain byte or the whole begin string
   typedef struct packed {
      logic [7:0] data;
      logic       is_begin;
      logic       msg_end;
      logic       frame_error;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   function automatic logic [7:0] begin_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = CHAR_EIGHT;
         3'd1:    c = CHAR_EQUAL;
         3'd2:    c = CHAR_F;
         3'd3:    c = CHAR_I;
         3'd4:    c = CHAR_X;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/fmd_req_if.sv =====
// fmd_req_if: input byte channel, valid/ready with one data byte
// no dependencies
`timescale 1ns / 1ps

interface fmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== hw/rtl/fmd_rsp_if.sv =====
// fmd_rsp_if: result channel, valid/ready with byte and framing flags
// no dependencies
`timescale 1ns / 1ps

interface fmd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       msg_start;
   logic       msg_end;
   logic       frame_error;
   logic       last;

   modport source (output valid, output out_byte, output msg_start, output msg_end,
                   output frame_error, output last, input ready);
   modport sink   (input valid, input out_byte, input msg_start, input msg_end,
                   input frame_error, input last, output ready);
endinterface

// ===== hw/rtl/fmd_front.sv =====
// fmd_front: accepts stream bytes, tracks framing state, pushes words to the queue
// depends on fmd_pkg and fmd_req_if
`timescale 1ns / 1ps

module fmd_front #(
   parameter int LEN_BITS = fmd_pkg::LEN_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   fmd_req_if.sink               req_chan,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data,
   output fmd_pkg::push_type     push,
   input  logic                  push_ready
);
   import fmd_pkg::*;

   localparam int AW    = LEN_BITS + 1;
   localparam int VW    = AW + 4;
   localparam int CMP_W = (AW > CFG_BITS) ? AW : CFG_BITS;
   localparam logic [VW-1:0] CAP_V = VW'(1) << LEN_BITS;

   phase_type        phase_ff, phase_in;
   logic [2:0]       match_ff, match_in;
   logic             saw_nine_ff, saw_nine_in;
   logic [AW-1:0]    accum_ff, accum_in;
   logic [AW-1:0]    left_ff, left_in;
   logic [15:0]      max_len_ff;

   logic             accept;
   logic [7:0]       b;
   logic             is_digit;
   logic [VW-1:0]    next_v;
   logic             too_large;
   logic [AW-1:0]    left_dec;

   assign req_chan.ready = push_ready;
   assign accept         = req_chan.valid && push_ready;
   assign b              = req_chan.data_byte;
   assign is_digit       = b inside {[CHAR_ZERO:CHAR_NINE]};

   // accum*10 + digit via shift-add
   assign next_v = (VW'(accum_ff) << 3) + (VW'(accum_ff) << 1)
                 + VW'(b - CHAR_ZERO);

   // limit is min(max_body_len, 2^LEN_BITS-1); top bit of accum means beyond that
   assign too_large = accum_ff[LEN_BITS] || (CMP_W'(accum_ff) > CMP_W'(max_len_ff));
   assign left_dec  = (left_ff != '0) ? left_ff - AW'(1) : left_ff;

   always_comb begin
      phase_in    = phase_ff;
      match_in    = match_ff;
      saw_nine_in = saw_nine_ff;
      accum_in    = accum_ff;
      left_in     = left_ff;
      push        = '0;
      push.entry.data = b;
      case (phase_ff)
         PH_HUNT: begin
            if (b == begin_char(match_ff)) begin
               if (match_ff == BEGIN_LAST) begin
                  match_in             = 3'd0;
                  saw_nine_in          = 1'b0;
                  phase_in             = PH_HEADER;
                  push.valid           = 1'b1;
                  push.entry.is_begin  = 1'b1;
               end else begin
                  match_in = match_ff + 3'd1;
               end
            end else begin
               match_in = (b == CHAR_EIGHT) ? 3'd1 : 3'd0;
            end
         end
         PH_HEADER: begin
            push.valid = 1'b1;
            if (saw_nine_ff && b == CHAR_EQUAL) begin
               phase_in    = PH_LENGTH;
               saw_nine_in = 1'b0;
               accum_in    = '0;
            end else begin
               saw_nine_in = (b == CHAR_NINE);
            end
         end
         PH_LENGTH: begin
            push.valid = 1'b1;
            if (is_digit) begin
               // saturate so an oversized length stays oversized
               if (accum_ff[LEN_BITS] || next_v > CAP_V) begin
                  accum_in = AW'(CAP_V);
               end else begin
                  accum_in = AW'(next_v);
               end
               saw_nine_in = 1'b1;
            end else if (b == SOH_BYTE && saw_nine_ff && !too_large) begin
               left_in     = accum_ff + AW'(TRAILER_LEN);
               phase_in    = PH_BODY;
               saw_nine_in = 1'b0;
            end else begin
               push.entry.frame_error = 1'b1;
               phase_in    = PH_HUNT;
               match_in    = 3'd0;
               saw_nine_in = 1'b0;
               accum_in    = '0;
               left_in     = '0;
            end
         end
         PH_BODY: begin
            push.valid = 1'b1;
            left_in    = left_dec;
            if (left_dec == '0) begin
               push.entry.msg_end = 1'b1;
               phase_in    = PH_HUNT;
               match_in    = 3'd0;
               saw_nine_in = 1'b0;
               accum_in    = '0;
            end
         end
         default: begin
            phase_in    = PH_HUNT;
            match_in    = 3'd0;
            saw_nine_in = 1'b0;
            accum_in    = '0;
            left_in     = '0;
         end
      endcase
      push.valid = push.valid && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         match_ff    <= 3'd0;
         saw_nine_ff <= 1'b0;
         accum_ff    <= '0;
         left_ff     <= '0;
         max_len_ff  <= CFG_RESET;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            match_ff    <= match_in;
            saw_nine_ff <= saw_nine_in;
            accum_ff    <= accum_in;
            left_ff     <= left_in;
         end
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

endmodule

// ===== hw/rtl/fmd_queue.sv =====
// fmd_queue: short word queue between the front and back parts
// depends on fmd_pkg
`timescale 1ns / 1ps

module fmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  fmd_pkg::push_type  push,
   output logic               push_ready,
   output fmd_pkg::head_type  head,
   input  logic               pop
);
   import fmd_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type        slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, rd_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = slots_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
         end
         count_ff <= count_ff + CW'(do_push) - CW'(do_pop);
      end
   end

endmodule

// ===== hw/rtl/fmd_back.sv =====
// fmd_back: drains queued words into results, expanding the begin string
// depends on fmd_pkg and fmd_rsp_if
`timescale 1ns / 1ps

module fmd_back (
   input  logic               clock,
   input  logic               reset,
   input  fmd_pkg::head_type  head,
   output logic               pop,
   fmd_rsp_if.source          rsp_chan
);
   import fmd_pkg::*;

   logic       valid_ff, valid_in;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] byte_ff, byte_in;
   logic       start_ff, start_in;
   logic       end_ff, end_in;
   logic       err_ff, err_in;
   logic       last_ff, last_in;
   logic       load, take;

   assign load = !valid_ff || rsp_chan.ready;
   assign take = load && head.valid;

   always_comb begin
      idx_in   = idx_ff;
      byte_in  = head.entry.data;
      start_in = 1'b0;
      end_in   = head.entry.msg_end;
      err_in   = head.entry.frame_error;
      last_in  = 1'b1;
      pop      = take;
      if (head.entry.is_begin) begin
         byte_in  = begin_char(idx_ff);
         start_in = (idx_ff == 3'd0);
         last_in  = (idx_ff == BEGIN_LAST);
         pop      = take && (idx_ff == BEGIN_LAST);
         if (take) begin
            idx_in = (idx_ff == BEGIN_LAST) ? 3'd0 : idx_ff + 3'd1;
         end
      end
      valid_in = take ? 1'b1 : (valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff  <= byte_in;
         start_ff <= start_in;
         end_ff   <= end_in;
         err_ff   <= err_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_byte    = byte_ff;
   assign rsp_chan.msg_start   = start_ff;
   assign rsp_chan.msg_end     = end_ff;
   assign rsp_chan.frame_error = err_ff;
   assign rsp_chan.last        = last_ff;

`ifndef SYNTHESIS
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= BEGIN_LAST)
      else $error("begin string index out of range");

   a_start_form: assert property (@(posedge clock) disable iff (reset)
      valid_ff && start_ff |-> !last_ff && byte_ff == CHAR_EIGHT && !end_ff && !err_ff)
      else $error("message start word malformed");

   a_err_form: assert property (@(posedge clock) disable iff (reset)
      valid_ff && err_ff |-> last_ff && !end_ff)
      else $error("error word carries wrong flags");

   a_mid_begin: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 3'd0 |-> head.valid && head.entry.is_begin)
      else $error("begin string expansion lost its queue word");
`endif

endmodule

// ===== hw/rtl/fix_message_deframer_unit.sv =====
// fix_message_deframer_unit: top level, front classifier, word queue and result stage
// depends on fmd_pkg, fmd_req_if, fmd_rsp_if, fmd_front, fmd_queue, fmd_back
//
//   channel    dir   handshake            payload
//   req_chan   in    valid/ready          data_byte[7:0]
//   rsp_chan   out   valid/ready          out_byte[7:0] msg_start msg_end frame_error last
//   csr_*      in    csr_wr_en            csr_wr_data[15:0] = max_body_len
//
// one byte accepted per cycle while the queue has room; hunting pushes only the begin word
// a completed begin string expands into five result bytes, other words into one
// an accepted byte reaches the result through the queue slot, then the output register
// synchronous reset clears framing state and queue; max_body_len resets to 65535
// both sides stall independently: the queue and the output register decouple them
`timescale 1ns / 1ps

module fix_message_deframer_unit #(
   parameter int LEN_BITS = fmd_pkg::LEN_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   fmd_req_if.sink      req_chan,
   fmd_rsp_if.source    rsp_chan,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);
   import fmd_pkg::*;

   push_type push;
   head_type head;
   logic     push_ready;
   logic     pop;

   fmd_front #(.LEN_BITS(LEN_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .push_ready  (push_ready)
   );

   fmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   fmd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
